>>> hdl/button_encoder_scanner_unit_defines.svh
// Assertion macros for the button/encoder scanner.
`ifndef BUTTON_ENCODER_SCANNER_UNIT_DEFINES_SVH
`define BUTTON_ENCODER_SCANNER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bes: same-cycle check failed");
// next-cycle implication
`define BES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bes: next-cycle check failed");
`else
`define BES_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/bes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

    localparam int RES_W     = 7;
    localparam int TICK_W    = 15;
    localparam int PRESS_W   = 16;
    localparam int COUNT_W   = 8;
    localparam int BTN_W     = 4;
    localparam int SET_W     = 6;
    localparam int CMD_W     = 4;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 2;
    localparam int DIV_W     = 7;
    localparam int DIV_CNT_W = 3;

    // seven restoring steps cover a 7-bit magnitude
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd6;

    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_ENC = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_CMD = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    localparam logic [IDX_W-1:0] REG_RES    = 2'd0;
    localparam logic [IDX_W-1:0] REG_SHORT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LONG   = 2'd2;
    localparam logic [IDX_W-1:0] REG_REPEAT = 2'd3;

    localparam logic signed [RES_W-1:0] RES_RESET    = 7'sd4;
    localparam logic [TICK_W-1:0]       SHORT_RESET  = 15'd100;
    localparam logic [TICK_W-1:0]       LONG_RESET   = 15'd2000;
    localparam logic [TICK_W-1:0]       REPEAT_RESET = 15'd400;

    localparam logic [CMD_W-1:0] CMD_NONE    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SHORT_1 = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SHORT_2 = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SHORT_3 = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SHORT_4 = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LONG_1  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_LONG_2  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_LONG_3  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_LONG_4  = 4'd8;

    // press sets: bits 0-3 buttons, bit 4 line A, bit 5 line B
    localparam logic [SET_W-1:0] SET_1  = 6'h01;
    localparam logic [SET_W-1:0] SET_2  = 6'h02;
    localparam logic [SET_W-1:0] SET_3  = 6'h04;
    localparam logic [SET_W-1:0] SET_4  = 6'h08;
    localparam logic [SET_W-1:0] SET_A  = 6'h10;
    localparam logic [SET_W-1:0] SET_B  = 6'h20;
    localparam logic [SET_W-1:0] SET_1A = 6'h11;
    localparam logic [SET_W-1:0] SET_2B = 6'h22;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd127;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TICK = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic tick;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

    // CMD_NONE means leave the pending command alone
    function automatic logic [CMD_W-1:0] long_code(input logic [SET_W-1:0] s,
                                                   input logic btn_mode);
        logic [CMD_W-1:0] c;
        begin
            case (s)
                SET_1:   c = CMD_LONG_1;
                SET_2:   c = CMD_LONG_2;
                SET_3:   c = CMD_LONG_3;
                SET_4:   c = CMD_LONG_4;
                SET_1A:  c = btn_mode ? CMD_LONG_4 : CMD_NONE;
                SET_2B:  c = btn_mode ? CMD_LONG_3 : CMD_NONE;
                default: c = CMD_NONE;
            endcase
            return c;
        end
    endfunction

    function automatic logic [CMD_W-1:0] short_code(input logic [SET_W-1:0] s,
                                                    input logic btn_mode);
        logic [CMD_W-1:0] c;
        begin
            case (s)
                SET_1:   c = CMD_SHORT_1;
                SET_2:   c = CMD_SHORT_2;
                SET_3:   c = CMD_SHORT_3;
                SET_4:   c = CMD_SHORT_4;
                SET_A:   c = btn_mode ? CMD_SHORT_4 : CMD_NONE;
                SET_B:   c = btn_mode ? CMD_SHORT_3 : CMD_NONE;
                default: c = CMD_NONE;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/bes_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bes_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [bes_pkg::OP_W-1:0] i_operation,
    input  wire logic                     i_out_stall,
    input  wire bes_pkg::t_stat           i_stat,
    output bes_pkg::t_cmd                 o_cmd,
    output logic                          o_in_stall,
    output logic                          o_out_valid
);

    bes_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    bes_pkg::t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            bes_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    case (i_operation)
                        bes_pkg::OP_TICK:     n_state = bes_pkg::S_TICK;
                        bes_pkg::OP_READ_ENC: n_state = bes_pkg::S_DIV;
                        bes_pkg::OP_READ_CMD: n_state = bes_pkg::S_DONE;
                        default:              n_state = bes_pkg::S_IDLE;
                    endcase
                end
            end
            bes_pkg::S_TICK: begin
                w_cmd.tick = 1'b1;
                n_state    = bes_pkg::S_IDLE;
            end
            bes_pkg::S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = bes_pkg::S_DONE;
                end
            end
            bes_pkg::S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = bes_pkg::S_IDLE;
                end
            end
            default: n_state = bes_pkg::S_IDLE;
        endcase
    end

    assign n_out_valid = w_cmd.out_load | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bes_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != bes_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> hdl/bes_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bes_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bes_pkg::t_cmd                 i_cmd,
    output bes_pkg::t_stat                     o_stat,
    input  wire logic [bes_pkg::OP_W-1:0]      i_operation,
    input  wire logic [bes_pkg::BTN_W-1:0]     i_buttons_pressed,
    input  wire logic                          i_line_a_active,
    input  wire logic                          i_line_b_active,
    input  wire logic                          i_cfg_we,
    input  wire logic [bes_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [bes_pkg::TICK_W-1:0]    i_cfg_data,
    output logic signed [bes_pkg::COUNT_W-1:0] o_encoder_steps,
    output logic [bes_pkg::CMD_W-1:0]          o_button_command
);

    // configuration
    logic signed [bes_pkg::RES_W-1:0] r_res;
    logic [bes_pkg::TICK_W-1:0]       r_short, r_long, r_repeat;

    // scanner state
    logic signed [bes_pkg::COUNT_W-1:0] r_count, n_count;
    logic [1:0]                         r_quad, n_quad;
    logic [bes_pkg::SET_W-1:0]          r_prev, n_prev;
    logic [bes_pkg::PRESS_W-1:0]        r_press, n_press;
    logic [bes_pkg::CMD_W-1:0]          r_pending, n_pending;

    // latched word
    logic [bes_pkg::OP_W-1:0]  r_op;
    logic [bes_pkg::BTN_W-1:0] r_btn;
    logic [1:0]                r_lines;

    // divider
    logic [bes_pkg::DIV_W-1:0]     r_div_rem, r_div_quo, r_div_den;
    logic [bes_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                          r_div_neg_q, r_div_neg_r;

    // result
    logic signed [bes_pkg::COUNT_W-1:0] r_steps, n_steps;
    logic [bes_pkg::CMD_W-1:0]          r_command, n_command;

    logic                         w_btn_mode;
    logic [bes_pkg::SET_W-1:0]    w_now;
    logic                         w_q_inc, w_q_dec;
    logic                         w_mv_up, w_mv_dn;
    logic [bes_pkg::PRESS_W-1:0]  w_press_inc, w_long_ext, w_rep_sum;
    logic [bes_pkg::CMD_W-1:0]    w_code;
    logic signed [bes_pkg::COUNT_W:0] w_moved_wide;
    logic signed [bes_pkg::COUNT_W-1:0] w_moved;
    logic [bes_pkg::COUNT_W-1:0]  w_count_abs;
    logic [bes_pkg::RES_W-1:0]    w_res_abs;
    logic [bes_pkg::DIV_W-1:0]    w_shift;
    logic [bes_pkg::DIV_W:0]      w_trial;
    logic                         w_ge;
    logic [bes_pkg::COUNT_W-1:0]  w_quo_ext, w_rem_ext;

    assign w_btn_mode = (r_res == '0);
    assign w_now      = {(w_btn_mode ? r_lines : 2'b00), r_btn};

    // Gray-code transitions, lines packed {B, A}
    assign w_q_dec = (r_quad == 2'd0 && r_lines == 2'd1) || (r_quad == 2'd1 && r_lines == 2'd3) ||
                     (r_quad == 2'd3 && r_lines == 2'd2) || (r_quad == 2'd2 && r_lines == 2'd0);
    assign w_q_inc = (r_quad == 2'd0 && r_lines == 2'd2) || (r_quad == 2'd2 && r_lines == 2'd3) ||
                     (r_quad == 2'd3 && r_lines == 2'd1) || (r_quad == 2'd1 && r_lines == 2'd0);

    assign w_press_inc = (&r_press) ? r_press : r_press + 1'b1;
    assign w_long_ext  = {1'b0, r_long};
    assign w_rep_sum   = {1'b0, r_long} + {1'b0, r_repeat};

    // divider step: remainder stays below the divisor (at most 64)
    assign w_shift = {r_div_rem[bes_pkg::DIV_W-2:0], r_div_quo[bes_pkg::DIV_W-1]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_div_den};
    assign w_ge    = ~w_trial[bes_pkg::DIV_W];

    assign w_count_abs = r_count[bes_pkg::COUNT_W-1] ? -r_count : r_count;
    assign w_res_abs   = r_res[bes_pkg::RES_W-1] ? -r_res : r_res;
    assign w_quo_ext   = {1'b0, r_div_quo};
    assign w_rem_ext   = {1'b0, r_div_rem};

    always_comb begin
        n_quad    = r_quad;
        n_prev    = r_prev;
        n_press   = r_press;
        n_pending = r_pending;
        n_steps   = r_steps;
        n_command = r_command;
        w_mv_up   = 1'b0;
        w_mv_dn   = 1'b0;
        w_code    = bes_pkg::CMD_NONE;

        if (i_cmd.tick) begin
            if (!w_btn_mode) begin
                w_mv_up = w_q_inc;
                w_mv_dn = w_q_dec;
                n_quad  = r_lines;
            end
            if (w_now != '0) begin
                if (w_now == r_prev) begin
                    n_press = w_press_inc;
                    if (w_press_inc == w_long_ext) begin
                        w_code = bes_pkg::long_code(r_prev, w_btn_mode);
                        if (w_code != bes_pkg::CMD_NONE) begin
                            n_pending = w_code;
                        end
                    end else if (w_btn_mode && w_press_inc == w_rep_sum) begin
                        w_mv_up = (r_prev == bes_pkg::SET_A);
                        w_mv_dn = (r_prev == bes_pkg::SET_B);
                        n_press = w_long_ext + 1'b1;
                    end
                end else begin
                    n_prev = w_now;
                end
            end else begin
                if (r_press > {1'b0, r_short} && r_press < w_long_ext) begin
                    w_code = bes_pkg::short_code(r_prev, w_btn_mode);
                    if (w_code != bes_pkg::CMD_NONE) begin
                        n_pending = w_code;
                    end
                end
                n_press = '0;
            end
        end

        w_moved_wide = {r_count[bes_pkg::COUNT_W-1], r_count}
                       + (w_mv_up ? 9'sd1 : 9'sd0) - (w_mv_dn ? 9'sd1 : 9'sd0);
        if (w_moved_wide > $signed({1'b0, bes_pkg::COUNT_MAX})) begin
            w_moved = bes_pkg::COUNT_MAX;
        end else if (w_moved_wide < $signed({1'b1, bes_pkg::COUNT_MIN})) begin
            w_moved = bes_pkg::COUNT_MIN;
        end else begin
            w_moved = w_moved_wide[bes_pkg::COUNT_W-1:0];
        end
        n_count = w_moved;

        if (i_cmd.out_load) begin
            if (r_op == bes_pkg::OP_READ_ENC) begin
                n_command = bes_pkg::CMD_NONE;
                if (w_btn_mode) begin
                    n_steps = r_count;
                    n_count = '0;
                end else begin
                    n_steps = r_div_neg_q ? -w_quo_ext : w_quo_ext;
                    n_count = r_div_neg_r ? -w_rem_ext : w_rem_ext;
                end
            end else begin
                n_steps   = '0;
                n_command = r_pending;
                n_pending = bes_pkg::CMD_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res     <= bes_pkg::RES_RESET;
            r_short   <= bes_pkg::SHORT_RESET;
            r_long    <= bes_pkg::LONG_RESET;
            r_repeat  <= bes_pkg::REPEAT_RESET;
            r_count   <= '0;
            r_quad    <= '0;
            r_prev    <= '0;
            r_press   <= '0;
            r_pending <= bes_pkg::CMD_NONE;
            r_div_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bes_pkg::REG_RES:    r_res    <= i_cfg_data[bes_pkg::RES_W-1:0];
                    bes_pkg::REG_SHORT:  r_short  <= i_cfg_data;
                    bes_pkg::REG_LONG:   r_long   <= i_cfg_data;
                    bes_pkg::REG_REPEAT: r_repeat <= i_cfg_data;
                    default: ;
                endcase
            end
            r_count   <= n_count;
            r_quad    <= n_quad;
            r_prev    <= n_prev;
            r_press   <= n_press;
            r_pending <= n_pending;
            if (i_cmd.load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_btn       <= i_buttons_pressed;
            r_lines     <= {i_line_b_active, i_line_a_active};
            r_div_quo   <= w_count_abs[bes_pkg::DIV_W-1:0];
            r_div_rem   <= '0;
            r_div_den   <= w_res_abs;
            r_div_neg_q <= r_count[bes_pkg::COUNT_W-1] ^ r_res[bes_pkg::RES_W-1];
            r_div_neg_r <= r_count[bes_pkg::COUNT_W-1];
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_ge ? w_trial[bes_pkg::DIV_W-1:0] : w_shift;
            r_div_quo <= {r_div_quo[bes_pkg::DIV_W-2:0], w_ge};
        end
        r_steps   <= n_steps;
        r_command <= n_command;
    end

    assign o_stat.div_last  = (r_div_cnt == bes_pkg::DIV_LAST);
    assign o_encoder_steps  = r_steps;
    assign o_button_command = r_command;

endmodule

`default_nettype wire

>>> hdl/button_encoder_scanner_unit.sv
// Button and quadrature encoder scanner.
// Input channel (i_in_valid / o_in_stall): one word per operation. A tick
// samples four buttons and the two encoder lines; it gives no result. An
// encoder read and a command read each give one result word on the output
// channel (o_out_valid / i_out_stall); operation 3 is dropped.
// One word is in work at a time. A tick goes through the tick state back to
// idle. A command read goes straight to the output load, which waits while
// the output register is held. An encoder read runs load, seven steps of a
// restoring divider for count / resolution (with resolution 0 the raw count
// is given and cleared), then the output load; a new word waits for idle.
// The output register holds a finished result while i_out_stall is high;
// the next word may still be taken and worked on, and only a new result
// waits for the register to empty.
// Configuration writes (i_cfg_valid, always ready) must go in only when no
// word is in work; the user is bound by this, the block does not enforce it.
// Synchronous reset restores default thresholds and resolution 4, clears the
// count, press state and pending command, and empties the output.
`timescale 1ns / 1ps
`default_nettype none
`include "button_encoder_scanner_unit_defines.svh"

module button_encoder_scanner_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bes_pkg::OP_W-1:0]      i_operation,
    input  wire logic [bes_pkg::BTN_W-1:0]     i_buttons_pressed,
    input  wire logic                          i_line_a_active,
    input  wire logic                          i_line_b_active,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [bes_pkg::COUNT_W-1:0] o_encoder_steps,
    output logic [bes_pkg::CMD_W-1:0]          o_button_command,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bes_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [bes_pkg::TICK_W-1:0]    i_cfg_data
);

    bes_pkg::t_cmd  w_cmd;
    bes_pkg::t_stat w_stat;
    logic           w_work_taken;
    logic           w_cmd_word;
    logic           w_out_held;

    assign o_cfg_ready = 1'b1;

    bes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    bes_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_operation       (i_operation),
        .i_buttons_pressed (i_buttons_pressed),
        .i_line_a_active   (i_line_a_active),
        .i_line_b_active   (i_line_b_active),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_encoder_steps   (o_encoder_steps),
        .o_button_command  (o_button_command)
    );

    assign w_work_taken = i_in_valid && !o_in_stall && i_operation != bes_pkg::OP_NONE;
    assign w_cmd_word   = o_out_valid && o_button_command != bes_pkg::CMD_NONE;
    assign w_out_held   = o_out_valid && i_out_stall;

    // a result is never loaded over a word still waiting to be taken
    `BES_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !w_out_held)
    // an accepted operation blocks the input until its work is done
    `BES_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_work_taken, o_in_stall)
    // command results carry no encoder steps
    `BES_ASSERT_SAME(a_cmd_no_steps, i_clk, i_rst_n, w_cmd_word, o_encoder_steps == '0)
    `BES_ASSERT_SAME(a_cmd_range, i_clk, i_rst_n, o_out_valid, o_button_command <= bes_pkg::CMD_LONG_4)

endmodule

`default_nettype wire

>>> test/button_scan_checker.sv
`timescale 1ns / 1ps

module button_scan_checker
    import bes_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic [OP_W-1:0]        i_operation,
    input  wire logic [BTN_W-1:0]       i_buttons_pressed,
    input  wire logic                   i_line_a_active,
    input  wire logic                   i_line_b_active,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic [COUNT_W-1:0]     i_encoder_steps,
    input  wire logic [CMD_W-1:0]       i_button_command,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [IDX_W-1:0]       i_cfg_index,
    input  wire logic [TICK_W-1:0]      i_cfg_data,
    output int                          o_results_due,
    output int                          o_mismatches
);

    typedef struct {
        logic signed [COUNT_W-1:0] steps;
        logic [CMD_W-1:0]          cmd;
    } t_scan_word;

    int resolution;
    int short_limit;
    int long_limit;
    int repeat_gap;

    int               enc_count;
    logic [1:0]       last_quad;
    logic [SET_W-1:0] held_set;
    int               press_count;
    logic [CMD_W-1:0] pending_cmd;

    t_scan_word due_words[$];
    t_scan_word got;
    t_scan_word want;

    function automatic int clamp_count(input int v);
        if (v > 127) return 127;
        if (v < -127) return -127;
        return v;
    endfunction

    task automatic apply_tick(input logic [BTN_W-1:0] btns, input logic a, input logic b);
        logic [1:0]       q;
        logic [SET_W-1:0] now_set;
        bit               keys;
        keys    = (resolution == 0);
        q       = {b, a};
        now_set = {2'b00, btns};
        if (keys) begin
            now_set[5:4] = q;
        end else begin
            if ((last_quad == 2'd0 && q == 2'd1) || (last_quad == 2'd1 && q == 2'd3) ||
                (last_quad == 2'd3 && q == 2'd2) || (last_quad == 2'd2 && q == 2'd0))
                enc_count = clamp_count(enc_count - 1);
            if ((last_quad == 2'd0 && q == 2'd2) || (last_quad == 2'd2 && q == 2'd3) ||
                (last_quad == 2'd3 && q == 2'd1) || (last_quad == 2'd1 && q == 2'd0))
                enc_count = clamp_count(enc_count + 1);
            last_quad = q;
        end

        if (now_set != '0) begin
            if (now_set == held_set) begin
                if (press_count < 65535) press_count++;
                if (press_count == long_limit) begin
                    case (held_set)
                        SET_1:   pending_cmd = CMD_LONG_1;
                        SET_2:   pending_cmd = CMD_LONG_2;
                        SET_3:   pending_cmd = CMD_LONG_3;
                        SET_4:   pending_cmd = CMD_LONG_4;
                        SET_1A:  if (keys) pending_cmd = CMD_LONG_4;
                        SET_2B:  if (keys) pending_cmd = CMD_LONG_3;
                        default: ;
                    endcase
                end else if (keys && press_count == long_limit + repeat_gap) begin
                    // autorepeat of the encoder lines used as keys
                    if (held_set == SET_A) enc_count = clamp_count(enc_count + 1);
                    if (held_set == SET_B) enc_count = clamp_count(enc_count - 1);
                    press_count = long_limit + 1;
                end
            end else begin
                held_set = now_set;
            end
        end else begin
            if (press_count > short_limit && press_count < long_limit) begin
                case (held_set)
                    SET_1:   pending_cmd = CMD_SHORT_1;
                    SET_2:   pending_cmd = CMD_SHORT_2;
                    SET_3:   pending_cmd = CMD_SHORT_3;
                    SET_4:   pending_cmd = CMD_SHORT_4;
                    SET_A:   if (keys) pending_cmd = CMD_SHORT_4;
                    SET_B:   if (keys) pending_cmd = CMD_SHORT_3;
                    default: ;
                endcase
            end
            press_count = 0;
        end
    endtask

    task automatic read_encoder(output t_scan_word w);
        int q;
        if (resolution != 0) begin
            q         = enc_count / resolution;
            enc_count = enc_count % resolution;
        end else begin
            q         = enc_count;
            enc_count = 0;
        end
        w.steps = q[COUNT_W-1:0];
        w.cmd   = CMD_NONE;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            resolution   = int'(RES_RESET);
            short_limit  = int'(SHORT_RESET);
            long_limit   = int'(LONG_RESET);
            repeat_gap   = int'(REPEAT_RESET);
            enc_count    = 0;
            last_quad    = 2'd0;
            held_set     = '0;
            press_count  = 0;
            pending_cmd  = CMD_NONE;
            o_mismatches = 0;
            due_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RES:    resolution  = int'($signed(i_cfg_data[RES_W-1:0]));
                    REG_SHORT:  short_limit = int'(i_cfg_data);
                    REG_LONG:   long_limit  = int'(i_cfg_data);
                    REG_REPEAT: repeat_gap  = int'(i_cfg_data);
                    default:    ;
                endcase
            end

            // compare before predicting: a word taken now cannot finish now
            if (i_out_valid && !i_out_stall) begin
                got.steps = i_encoder_steps;
                got.cmd   = i_button_command;
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got steps %0d command %0d",
                             $time, got.steps, got.cmd);
                    o_mismatches++;
                end else begin
                    want = due_words.pop_front();
                    if (got.steps !== want.steps) begin
                        $display("%0t: encoder steps expected %0d, got %0d",
                                 $time, want.steps, got.steps);
                        o_mismatches++;
                    end
                    if (got.cmd !== want.cmd) begin
                        $display("%0t: button command expected %0d, got %0d",
                                 $time, want.cmd, got.cmd);
                        o_mismatches++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                case (i_operation)
                    OP_TICK: apply_tick(i_buttons_pressed, i_line_a_active, i_line_b_active);
                    OP_READ_ENC: begin
                        read_encoder(want);
                        due_words.push_back(want);
                    end
                    OP_READ_CMD: begin
                        want.steps  = '0;
                        want.cmd    = pending_cmd;
                        pending_cmd = CMD_NONE;
                        due_words.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_results_due = due_words.size();
    end

endmodule

>>> test/button_encoder_scanner_unit_test.sv
`timescale 1ns / 1ps

module button_encoder_scanner_unit_test;
    import bes_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 12;
    localparam int PHASE_WORDS = 24;
    localparam int NUM_SETUPS  = 13;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [OP_W-1:0]    operation  = OP_TICK;
    logic [BTN_W-1:0]   buttons    = '0;
    logic               line_a     = 1'b0;
    logic               line_b     = 1'b0;
    logic               out_stall  = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic [IDX_W-1:0]   cfg_index  = REG_RES;
    logic [TICK_W-1:0]  cfg_data   = '0;

    wire logic               in_stall;
    wire logic               out_valid;
    wire logic [COUNT_W-1:0] enc_steps;
    wire logic [CMD_W-1:0]   btn_cmd;
    wire logic               cfg_ready;

    int results_due;
    int mismatches;

    // settings after the directed part: resolution, short, long, autorepeat
    int setup_res[NUM_SETUPS]    = '{1, -1, 0, 0, -32, 32, 63, -64, 0, 2, 0, -3, 0};
    int setup_short[NUM_SETUPS]  = '{2, 0, 3, 0, 32767, 1, 4, 2, 4, 3, 2, 1, 5};
    int setup_long[NUM_SETUPS]   = '{10, 6, 12, 1, 32767, 8, 0, 9, 9, 60, 7, 5, 32767};
    int setup_repeat[NUM_SETUPS] = '{3, 2, 4, 1, 1, 0, 5, 1, 0, 2, 1, 2, 32767};

    int         cur_res    = int'(RES_RESET);
    int         cur_short  = int'(SHORT_RESET);
    int         cur_long   = int'(LONG_RESET);
    int         cur_repeat = int'(REPEAT_RESET);
    bit         calm       = 1'b0;
    int         phase_words;
    logic [1:0] quad_now   = 2'd0;
    int         idle_cycles = 0;

    button_encoder_scanner_unit uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (operation),
        .i_buttons_pressed (buttons),
        .i_line_a_active   (line_a),
        .i_line_b_active   (line_b),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_encoder_steps   (enc_steps),
        .o_button_command  (btn_cmd),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    button_scan_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_operation       (operation),
        .i_buttons_pressed (buttons),
        .i_line_a_active   (line_a),
        .i_line_b_active   (line_b),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_encoder_steps   (enc_steps),
        .i_button_command  (btn_cmd),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_results_due     (results_due),
        .o_mismatches      (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pause_len();
        if (calm) return 0;
        return $urandom_range(0, 16);
    endfunction

    // positive direction of the count: 0 -> 2 -> 3 -> 1 -> 0
    function automatic logic [1:0] next_quad(input logic [1:0] q, input bit up);
        case (q)
            2'd0:    return up ? 2'd2 : 2'd1;
            2'd2:    return up ? 2'd3 : 2'd0;
            2'd3:    return up ? 2'd1 : 2'd2;
            default: return up ? 2'd0 : 2'd3;
        endcase
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input logic [BTN_W-1:0] btns,
                        input logic a, input logic b);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        buttons   <= btns;
        line_a    <= a;
        line_b    <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (op != OP_NONE) phase_words++;
    endtask

    task automatic send_noise();
        send(OP_W'($urandom_range(0, 3)), BTN_W'($urandom_range(0, 15)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // called on a falling edge; drains the block before touching registers
    task automatic configure(input int res, input int sh, input int lg, input int rp);
        logic [RES_W-1:0] res_bits;
        res_bits = res[RES_W-1:0];
        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        write_reg(REG_RES, TICK_W'(res_bits));
        write_reg(REG_SHORT, TICK_W'(sh));
        write_reg(REG_LONG, TICK_W'(lg));
        write_reg(REG_REPEAT, TICK_W'(rp));
        cfg_valid  <= 1'b0;
        cur_res    = res;
        cur_short  = sh;
        cur_long   = lg;
        cur_repeat = rp;
    endtask

    function automatic logic [SET_W-1:0] pick_set();
        if (cur_res == 0) begin
            case ($urandom_range(0, 8))
                0:       return SET_1;
                1:       return SET_2;
                2:       return SET_3;
                3:       return SET_4;
                4:       return SET_A;
                5:       return SET_B;
                6:       return SET_1A;
                7:       return SET_2B;
                default: return SET_W'($urandom_range(1, 63));
            endcase
        end
        case ($urandom_range(0, 4))
            0:       return SET_1;
            1:       return SET_2;
            2:       return SET_3;
            3:       return SET_4;
            default: return SET_W'($urandom_range(1, 15));
        endcase
    endfunction

    // hold lengths cluster around the thresholds
    function automatic int press_len();
        int d;
        case ($urandom_range(0, 5))
            0: d = $urandom_range(1, 3);
            1: d = (cur_long > cur_short + 2) ? $urandom_range(cur_short + 1, cur_long - 1)
                                              : cur_short + 1;
            2: d = cur_long;
            3: d = cur_long + $urandom_range(1, 3) * cur_repeat + $urandom_range(0, 2);
            4: d = cur_short;
            default: d = $urandom_range(1, 40);
        endcase
        d += $urandom_range(0, 1);
        if (d < 1 || d > 400) d = $urandom_range(1, 40);
        return d;
    endfunction

    task automatic hold_set(input logic [SET_W-1:0] s, input int n);
        for (int i = 0; i < n; i++) begin
            if (cur_res == 0) begin
                send(OP_TICK, s[3:0], s[4], s[5]);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    quad_now = next_quad(quad_now, 1'($urandom_range(0, 1)));
                send(OP_TICK, s[3:0], quad_now[0], quad_now[1]);
            end
        end
    endtask

    task automatic press_sequence();
        hold_set(pick_set(), press_len());
        // sometimes slide into another set without releasing
        if ($urandom_range(0, 4) == 0) hold_set(pick_set(), press_len());
        hold_set('0, $urandom_range(1, 2));
        if ($urandom_range(0, 3) != 0)
            send(OP_READ_CMD, BTN_W'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 2) == 0)
            send(OP_READ_ENC, BTN_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic turn_sequence();
        int               n;
        bit               up;
        logic [BTN_W-1:0] btns;
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 150) : $urandom_range(1, 12);
        up   = 1'($urandom_range(0, 1));
        btns = ($urandom_range(0, 3) == 0) ? BTN_W'($urandom_range(0, 15)) : '0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0:       quad_now = ~quad_now;
                1:       ;
                2, 3, 4: quad_now = next_quad(quad_now, !up);
                default: quad_now = next_quad(quad_now, up);
            endcase
            send(OP_TICK, btns, quad_now[0], quad_now[1]);
        end
        send(OP_READ_ENC, BTN_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // receiver: random stall before each word, none when calm
    initial begin
        int n;
        forever begin
            n = pause_len();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: empty reads, dropped operation, quadrature both ways
        send(OP_READ_CMD, 4'h0, 1'b0, 1'b0);
        send(OP_READ_ENC, 4'h0, 1'b0, 1'b0);
        send(OP_NONE, 4'hF, 1'b1, 1'b1);
        send(OP_TICK, 4'h0, 1'b1, 1'b0);
        send(OP_TICK, 4'h0, 1'b1, 1'b1);
        send(OP_TICK, 4'h0, 1'b0, 1'b1);
        send(OP_TICK, 4'h0, 1'b0, 1'b0);
        send(OP_TICK, 4'h0, 1'b0, 1'b1);
        send(OP_TICK, 4'h0, 1'b1, 1'b1);
        send(OP_TICK, 4'hF, 1'b0, 1'b0);
        send(OP_READ_ENC, 4'hF, 1'b1, 1'b1);

        // lines as keys: combined long press, then autorepeat on line B
        configure(0, 1, 3, 2);
        repeat (4) send(OP_TICK, 4'h1, 1'b1, 1'b0);
        send(OP_TICK, 4'h0, 1'b0, 1'b0);
        send(OP_READ_CMD, 4'h0, 1'b0, 1'b0);
        repeat (6) send(OP_TICK, 4'h0, 1'b0, 1'b1);
        send(OP_TICK, 4'h0, 1'b0, 1'b0);
        send(OP_READ_ENC, 4'h0, 1'b0, 1'b0);

        for (int p = 0; p < NUM_SETUPS; p++) begin
            configure(setup_res[p], setup_short[p], setup_long[p], setup_repeat[p]);
            calm        = ($urandom_range(0, 3) == 0);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: press_sequence();
                    8, 9, 10, 11, 12, 13:   turn_sequence();
                    14, 15, 16:             repeat ($urandom_range(1, 4)) send_noise();
                    default: begin
                        if ($urandom_range(0, 1))
                            send(OP_READ_CMD, BTN_W'($urandom), 1'($urandom), 1'($urandom));
                        else
                            send(OP_READ_ENC, BTN_W'($urandom), 1'($urandom), 1'($urandom));
                    end
                endcase
            end
        end

        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> button_encoder_scanner_unit.f
+incdir+hdl
hdl/bes_pkg.sv
hdl/bes_ctrl.sv
hdl/bes_datapath.sv
hdl/button_encoder_scanner_unit.sv
test/button_scan_checker.sv
test/button_encoder_scanner_unit_test.sv
